[hdl/sorted_goal_reference_counter_macros.svh]
// Assertion macros for the sorted goal reference counter.
// Included by every file that carries concurrent assertions.
`ifndef SORTED_GOAL_REFERENCE_COUNTER_MACROS_SVH
`define SORTED_GOAL_REFERENCE_COUNTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define SGRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);
// Check that a condition never holds outside reset.
`define SGRC_NEVER(lbl, clk, rstn, expr, msg) \
  `SGRC_ASSERT(lbl, clk, rstn, !(expr), msg)
`else
`define SGRC_ASSERT(lbl, clk, rstn, prop, msg)
`define SGRC_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[hdl/sgrc_pkg.sv]
// Shared types and codes of the sorted goal reference counter.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps
package sgrc_pkg;

  localparam int GOAL_W  = 8;
  localparam int COUNT_W = 8;
  localparam int TOTAL_W = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_FULL = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CHANGE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  typedef enum logic {
    ALU_INC = 1'b0,
    ALU_DEC = 1'b1
  } alu_op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GOAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GOAL = 1'b1;

  typedef struct packed {
    logic [GOAL_W-1:0]  goal;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic               lt;
    logic               eq;
    logic [COUNT_W-1:0] res;
  } alu_res_t;

  typedef struct packed {
    status_e            status;
    logic [TOTAL_W-1:0] total;
    logic [GOAL_W-1:0]  highest;
  } res_t;

endpackage

[hdl/sgrc_if.sv]
// Handshake channels of the sorted goal reference counter: request,
// response and configuration write. Depends on sgrc_pkg.
`timescale 1ns / 1ps
interface sgrc_req_if import sgrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [GOAL_W-1:0] goal;
  logic [GOAL_W-1:0] new_goal;
  modport source (output valid, mode, goal, new_goal, input ready);
  modport sink (input valid, mode, goal, new_goal, output ready);
endinterface

interface sgrc_rsp_if import sgrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [TOTAL_W-1:0] total_files;
  logic [GOAL_W-1:0]  highest_goal;
  modport source (output valid, status, total_files, highest_goal, input ready);
  modport sink (input valid, status, total_files, highest_goal, output ready);
endinterface

interface sgrc_cfg_if import sgrc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GOAL_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/sgrc_mem.sv]
// Entry memory: one write port, one read port with registered read data.
// Depends on sgrc_pkg for the entry type.
`timescale 1ns / 1ps
module sgrc_mem import sgrc_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sgrc_alu.sv]
// Shared compare and count step unit of the sequencer.
// Depends on sgrc_pkg.
`timescale 1ns / 1ps
module sgrc_alu import sgrc_pkg::*; (
  input  alu_op_e            op_i,
  input  logic [GOAL_W-1:0]  a_i,
  input  logic [GOAL_W-1:0]  b_i,
  output alu_res_t           res_o
);

  assign res_o.lt  = a_i < b_i;
  assign res_o.eq  = a_i == b_i;
  assign res_o.res = (op_i == ALU_DEC) ? a_i - COUNT_ONE : a_i + COUNT_ONE;

endmodule

[hdl/sgrc_ctrl.sv]
// Sequencer: range check, linear search, shift insert and erase, totals.
// Depends on sgrc_pkg, sgrc_alu, sgrc_mem and the assertion macros.
`timescale 1ns / 1ps
`include "sorted_goal_reference_counter_macros.svh"
module sgrc_ctrl import sgrc_pkg::*; #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [GOAL_W-1:0] goal_i,
  input  logic [GOAL_W-1:0] new_goal_i,
  input  logic [GOAL_W-1:0] min_goal_i,
  input  logic [GOAL_W-1:0] max_goal_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  localparam int IW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TW = $clog2(TABLE_ENTRIES * 255 + 1);
  localparam int SW = (TW > TOTAL_W) ? TW : TOTAL_W;
  localparam logic [IW-1:0] FULL_USED = IW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] ONE_I = IW'(1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHKLO = 4'd1;
  localparam logic [3:0] ST_CHKHI = 4'd2;
  localparam logic [3:0] ST_SRD   = 4'd3;
  localparam logic [3:0] ST_SCMP  = 4'd4;
  localparam logic [3:0] ST_DEC   = 4'd5;
  localparam logic [3:0] ST_SHRD  = 4'd6;
  localparam logic [3:0] ST_SHWR  = 4'd7;
  localparam logic [3:0] ST_INS   = 4'd8;
  localparam logic [3:0] ST_HIRD  = 4'd9;
  localparam logic [3:0] ST_HICAP = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0]        st_q, st_d;
  logic              is_add_q, is_add_d;
  logic              chg_q, chg_d;
  logic              hit_q, hit_d;
  logic [GOAL_W-1:0] g_q, g_d;
  logic [GOAL_W-1:0] ng_q, ng_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     pos_q, pos_d;
  logic [IW-1:0]     used_q, used_d;
  logic [TW-1:0]     total_q, total_d;
  status_e           status_q, status_d;
  logic [GOAL_W-1:0] high_q, high_d;

  logic [IW-1:0]     idx_p1, idx_m1, used_m1;
  logic              rm_done;

  alu_op_e           alu_op;
  logic [GOAL_W-1:0] alu_a, alu_b;
  alu_res_t          alu;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;

  logic [SW-1:0]     tot_ext;

  sgrc_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  sgrc_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign idx_p1  = idx_q + ONE_I;
  assign idx_m1  = idx_q - ONE_I;
  assign used_m1 = used_q - ONE_I;

  // Route operands of the shared unit by step.
  always_comb begin
    alu_op = ALU_INC;
    alu_a  = '0;
    alu_b  = '0;
    case (st_q)
      ST_CHKLO: begin
        alu_a = g_q;
        alu_b = min_goal_i;
      end
      ST_CHKHI: begin
        alu_a = max_goal_i;
        alu_b = g_q;
      end
      ST_SCMP: begin
        alu_a = mem_rdata.goal;
        alu_b = g_q;
      end
      ST_DEC: begin
        alu_op = is_add_q ? ALU_INC : ALU_DEC;
        alu_a  = cnt_q;
        alu_b  = is_add_q ? COUNT_FULL : COUNT_ONE;
      end
      default: begin
        alu_op = ALU_INC;
      end
    endcase
  end

  always_comb begin
    st_d      = st_q;
    is_add_d  = is_add_q;
    chg_d     = chg_q;
    hit_d     = hit_q;
    g_d       = g_q;
    ng_d      = ng_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    used_d    = used_q;
    total_d   = total_q;
    status_d  = status_q;
    high_d    = high_q;
    rm_done   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q[AW-1:0];
    mem_wdata = '{goal: g_q, count: alu.res};
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (st_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          g_d      = goal_i;
          ng_d     = new_goal_i;
          status_d = STATUS_OK;
          idx_d    = '0;
          chg_d    = 1'b0;
          case (mode_e'(mode_i))
            MODE_ADD: begin
              is_add_d = 1'b1;
              st_d     = ST_CHKLO;
            end
            MODE_REMOVE: begin
              is_add_d = 1'b0;
              st_d     = ST_SRD;
            end
            MODE_CHANGE: begin
              is_add_d = 1'b0;
              chg_d    = 1'b1;
              st_d     = ST_SRD;
            end
            default: begin
              st_d = ST_HIRD;
            end
          endcase
        end
      end
      ST_CHKLO: begin
        if (alu.lt) begin
          status_d = STATUS_INVALID;
          st_d     = ST_HIRD;
        end else begin
          st_d = ST_CHKHI;
        end
      end
      ST_CHKHI: begin
        if (alu.lt) begin
          status_d = STATUS_INVALID;
          st_d     = ST_HIRD;
        end else begin
          idx_d = '0;
          st_d  = ST_SRD;
        end
      end
      ST_SRD: begin
        if (idx_q < used_q) begin
          mem_re = 1'b1;
          st_d   = ST_SCMP;
        end else begin
          pos_d = idx_q;
          hit_d = 1'b0;
          st_d  = ST_DEC;
        end
      end
      ST_SCMP: begin
        if (alu.lt) begin
          idx_d = idx_p1;
          st_d  = ST_SRD;
        end else begin
          pos_d = idx_q;
          hit_d = alu.eq;
          cnt_d = mem_rdata.count;
          st_d  = ST_DEC;
        end
      end
      ST_DEC: begin
        if (is_add_q) begin
          if (hit_q && !alu.eq) begin
            mem_we  = 1'b1;
            total_d = total_q + TW'(1);
            st_d    = ST_HIRD;
          end else if (used_q == FULL_USED) begin
            status_d = STATUS_FULL;
            st_d     = ST_HIRD;
          end else begin
            idx_d = used_q;
            st_d  = ST_SHRD;
          end
        end else begin
          if (!hit_q) begin
            status_d = STATUS_MISSING;
            st_d     = ST_HIRD;
          end else begin
            total_d = total_q - TW'(1);
            if (!alu.eq) begin
              mem_we  = 1'b1;
              rm_done = 1'b1;
            end else begin
              idx_d = pos_q;
              st_d  = ST_SHRD;
            end
          end
        end
      end
      ST_SHRD: begin
        if (is_add_q) begin
          if (idx_q > pos_q) begin
            mem_re    = 1'b1;
            mem_raddr = idx_m1[AW-1:0];
            st_d      = ST_SHWR;
          end else begin
            st_d = ST_INS;
          end
        end else begin
          if (idx_p1 < used_q) begin
            mem_re    = 1'b1;
            mem_raddr = idx_p1[AW-1:0];
            st_d      = ST_SHWR;
          end else begin
            used_d  = used_m1;
            rm_done = 1'b1;
          end
        end
      end
      ST_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = mem_rdata;
        idx_d     = is_add_q ? idx_m1 : idx_p1;
        st_d      = ST_SHRD;
      end
      ST_INS: begin
        mem_we    = 1'b1;
        mem_wdata = '{goal: g_q, count: COUNT_ONE};
        used_d    = used_q + ONE_I;
        total_d   = total_q + TW'(1);
        st_d      = ST_HIRD;
      end
      ST_HIRD: begin
        if (used_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = used_m1[AW-1:0];
          st_d      = ST_HICAP;
        end else begin
          high_d = '0;
          st_d   = ST_DONE;
        end
      end
      ST_HICAP: begin
        high_d = mem_rdata.goal;
        st_d   = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // A finished remove either hands over to the add of a change or ends.
    if (rm_done) begin
      if (chg_q) begin
        is_add_d = 1'b1;
        chg_d    = 1'b0;
        g_d      = ng_q;
        st_d     = ST_CHKLO;
      end else begin
        st_d = ST_HIRD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      is_add_q <= 1'b0;
      chg_q    <= 1'b0;
      hit_q    <= 1'b0;
      idx_q    <= '0;
      pos_q    <= '0;
      used_q   <= '0;
      total_q  <= '0;
      status_q <= STATUS_OK;
    end else begin
      st_q     <= st_d;
      is_add_q <= is_add_d;
      chg_q    <= chg_d;
      hit_q    <= hit_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
      used_q   <= used_d;
      total_q  <= total_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q    <= g_d;
    ng_q   <= ng_d;
    cnt_q  <= cnt_d;
    high_q <= high_d;
  end

  // Saturate the running total to the result field.
  assign tot_ext = SW'(total_q);
  assign res_o.status  = status_q;
  assign res_o.total   = (tot_ext > SW'(TOTAL_MAX)) ? TOTAL_MAX : tot_ext[TOTAL_W-1:0];
  assign res_o.highest = high_q;

  `SGRC_NEVER(a_used_bound, clk_i, rst_ni, used_q > FULL_USED, "entry count over table size")
  `SGRC_NEVER(a_idx_bound, clk_i, rst_ni, idx_q > used_q, "scan index past used entries")
  `SGRC_NEVER(a_empty_total, clk_i, rst_ni, used_q == '0 && total_q != '0, "total without entries")
  `SGRC_ASSERT(a_total_src, clk_i, rst_ni, (total_q != $past(total_q)) |-> ($past(st_q) == ST_DEC || $past(st_q) == ST_INS), "total changed outside update step")

endmodule

[hdl/sorted_goal_reference_counter.sv]
// Sorted goal reference counter: top level with configuration registers,
// result register, sequencer. Depends on sgrc_pkg, sgrc_if, sgrc_ctrl.
`timescale 1ns / 1ps
//
// Usage:
//   req_i   request transfer: mode (add, remove, change), goal, new_goal.
//   rsp_o   one response transfer per request: status, total_files and
//           highest_goal after the operation.
//   cfg_i   register write transfer; index 0 min_valid_goal, index 1
//           max_valid_goal. Always ready; write only while no request is open.
// Sequencing: one request at a time. A single compare and step unit walks
//   the table: the range check of an add, a scan of the entries (registered
//   memory read, then compare) that may run off the end, a decision step,
//   a read and a write per entry moved on insert or erase plus a closing
//   step, the insert step, the fetch of the highest goal (registered read,
//   then capture) and the hand-over of the result. A change runs a remove
//   and then an add. The response is offered in the cycle after the
//   hand-over, and the next request is taken in the cycle after it too.
// Reset: table empty, totals zero, min_valid_goal 1, max_valid_goal 40.
// Stall: a finished response waits in the output register; the next request
//   is accepted meanwhile, and its result waits until the register drains.
//
module sorted_goal_reference_counter import sgrc_pkg::*; #(
  parameter int TABLE_ENTRIES = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  sgrc_req_if.sink  req_i,
  sgrc_rsp_if.source rsp_o,
  sgrc_cfg_if.sink  cfg_i
);

  logic [GOAL_W-1:0] min_goal_q;
  logic [GOAL_W-1:0] max_goal_q;

  logic   res_valid;
  logic   res_ready;
  res_t   res;

  logic   out_valid_q;
  res_t   out_q;

  // Configuration writes are always accepted and registered; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_goal_q <= GOAL_W'(1);
      max_goal_q <= GOAL_W'(40);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MIN_GOAL: min_goal_q <= cfg_i.data;
        CFG_MAX_GOAL: max_goal_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  sgrc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .mode_i      (req_i.mode),
    .goal_i      (req_i.goal),
    .new_goal_i  (req_i.new_goal),
    .min_goal_i  (min_goal_q),
    .max_goal_i  (max_goal_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Load the output register whenever it is empty or drains this cycle.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the payload while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.total_files  = out_q.total;
  assign rsp_o.highest_goal = out_q.highest;

endmodule
